@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands, clocked on clk_i, off in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent checked in the same cycle
`define SFS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the next cycle
`define SFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/sfs_pkg.sv @@
// ---------------------------------------------------------------------------
// sfs_pkg
// Types and fixed widths of the sparse forward substitution block.
// ---------------------------------------------------------------------------
package sfs_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned ACC_W  = 64;
  localparam int unsigned IDX_W  = 10;
  localparam int unsigned STEP_W = $clog2(DATA_W + 1);

  typedef struct packed {
    logic [IDX_W-1:0]         row_index;
    logic signed [DATA_W-1:0] entry_value;
    logic signed [DATA_W-1:0] rhs_value;
    logic                     column_end;
    logic                     matrix_end;
  } sfs_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] solution_value;
    logic [IDX_W-1:0]         solution_index;
    logic                     zero_pivot;
    logic                     overflow;
    logic                     last_result;
  } sfs_out_t;

  // divider status toward the sequencer
  typedef struct packed {
    logic              done;
    logic              big;
    logic [DATA_W-1:0] quotient;
  } sfs_div_res_t;

endpackage

@@ rtl/sfs_solution_mem.sv @@
// ---------------------------------------------------------------------------
// sfs_solution_mem
// Solution store: one write port, one registered read port, no reset.
// ---------------------------------------------------------------------------
module sfs_solution_mem import sfs_pkg::*; #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned ADDR_W = 10
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/sfs_divider.sv @@
// ---------------------------------------------------------------------------
// sfs_divider
// Restoring divider, 64 by 32 bit unsigned, one quotient bit per cycle.
// Flags quotients of 2^32 and up without iterating.
// ---------------------------------------------------------------------------
module sfs_divider import sfs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [ACC_W-1:0]  dividend_i,
  input  logic [DATA_W-1:0] divisor_i,
  output sfs_div_res_t      res_o
);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] cnt_q;
  logic              big_q;
  logic [DATA_W-1:0] rem_q;
  logic [DATA_W-1:0] quo_q;
  logic [DATA_W-1:0] div_q;

  logic [DATA_W:0]   trial;
  logic              fits;
  logic [DATA_W:0]   diff;
  logic              start_big;

  assign start_big = dividend_i[ACC_W-1:DATA_W] >= divisor_i;
  assign trial     = {rem_q, quo_q[DATA_W-1]};
  assign fits      = trial >= {1'b0, div_q};
  assign diff      = trial - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (start_big) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          cnt_q  <= STEP_W'(DATA_W);
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q - STEP_W'(1);
        if (cnt_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      big_q <= start_big;
      rem_q <= dividend_i[ACC_W-1:DATA_W];
      quo_q <= dividend_i[DATA_W-1:0];
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      quo_q <= {quo_q[DATA_W-2:0], fits};
    end
  end

  assign res_o.done     = done_q;
  assign res_o.big      = big_q;
  assign res_o.quotient = quo_q;

endmodule

@@ rtl/sparse_forward_substitution.sv @@
// ---------------------------------------------------------------------------
// sparse_forward_substitution
// Column-wise sparse forward substitution, signed fixed point, with a
// saturating 64-bit dot accumulator and an iterative divider on the diagonal.
// ---------------------------------------------------------------------------
// channel  direction  signals                          payload
// in       input      in_valid_i / in_stall_o          sfs_in_t  in_data_i
// out      output     out_valid_o / out_stall_i        sfs_out_t out_data_o
//
// Off-diagonal item: accept, multiply, accumulate; a row beyond the store is
//   accepted and dropped.
// Diagonal item: numerator, divider start, one-bit-per-cycle divide (32 steps),
//   emit; zero pivots skip the divide; quotients of 2^32 or more skip its steps.
// Reset: control and counter clear at once; the store has no clearing pass.
// A result waits in the output register; the next item is taken meanwhile,
//   and a diagonal finishing while the register is full holds until it frees.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sparse_forward_substitution import sfs_pkg::*; #(
  parameter int unsigned MAX_ORDER     = 1024,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  sfs_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output sfs_out_t out_data_o
);

  localparam int unsigned AW = $clog2(MAX_ORDER);
  localparam int unsigned WA = (AW > IDX_W) ? AW : IDX_W;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic [DATA_W-1:0] RES_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] RES_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_NUM,
    ST_DSTART,
    ST_DIV,
    ST_EMIT
  } state_e;

  state_e                   state_q;
  logic                     out_valid_q;
  sfs_out_t                 out_data_q;
  logic [AW-1:0]            cnt_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic                     acc_sat_q;

  sfs_in_t                  item_q;
  logic signed [ACC_W-1:0]  product_q;
  logic signed [ACC_W-1:0]  num_q;
  logic                     neg_q;
  logic                     ovf_q;
  logic                     zp_q;
  logic [DATA_W-1:0]        result_q;

  logic                     in_accept;
  logic                     emit_fire;
  logic [WA-1:0]            row_ext;
  logic                     row_in_range;
  logic                     mem_re;
  logic [DATA_W-1:0]        mem_rdata;
  logic signed [DATA_W-1:0] x_s;
  logic signed [ACC_W-1:0]  product_d;
  logic signed [ACC_W-1:0]  sum;
  logic                     sum_ovf;
  logic signed [ACC_W-1:0]  scaled_b;
  logic signed [ACC_W-1:0]  diff;
  logic                     diff_ovf;
  logic [ACC_W-1:0]         num_mag;
  logic [DATA_W-1:0]        den_mag;
  logic                     div_start;
  sfs_div_res_t             div_res;
  logic [DATA_W-1:0]        q_result;
  logic                     q_ovf;
  logic [AW-1:0]            cnt_next;

  assign in_stall_o   = (state_q != ST_IDLE);
  assign in_accept    = in_valid_i && !in_stall_o;
  assign emit_fire    = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);
  assign row_ext      = WA'(in_data_i.row_index);
  assign row_in_range = (32'(in_data_i.row_index) < MAX_ORDER);
  assign mem_re       = in_accept && !in_data_i.column_end && row_in_range;

  sfs_solution_mem #(
    .DEPTH  (MAX_ORDER),
    .ADDR_W (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (emit_fire),
    .waddr_i (cnt_q),
    .wdata_i (result_q),
    .re_i    (mem_re),
    .raddr_i (row_ext[AW-1:0]),
    .rdata_o (mem_rdata)
  );

  // multiply, saturating accumulate, numerator
  assign x_s       = $signed(mem_rdata);
  assign product_d = item_q.entry_value * x_s;
  assign sum       = acc_q + product_q;
  assign sum_ovf   = (acc_q[ACC_W-1] == product_q[ACC_W-1]) &&
                     (sum[ACC_W-1] != acc_q[ACC_W-1]);
  assign scaled_b  = ACC_W'(item_q.rhs_value) <<< FRACTION_BITS;
  assign diff      = scaled_b - acc_q;
  assign diff_ovf  = (scaled_b[ACC_W-1] != acc_q[ACC_W-1]) &&
                     (diff[ACC_W-1] != scaled_b[ACC_W-1]);

  assign num_mag   = num_q[ACC_W-1] ? (~num_q + ACC_W'(1)) : num_q;
  assign den_mag   = item_q.entry_value[DATA_W-1] ?
                     (~item_q.entry_value + DATA_W'(1)) : item_q.entry_value;
  assign div_start = (state_q == ST_DSTART);

  sfs_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (num_mag),
    .divisor_i  (den_mag),
    .res_o      (div_res)
  );

  // quotient sign and saturation
  always_comb begin
    q_ovf    = 1'b0;
    q_result = neg_q ? (~div_res.quotient + DATA_W'(1)) : div_res.quotient;
    if (div_res.big) begin
      q_ovf    = 1'b1;
      q_result = neg_q ? RES_MIN : RES_MAX;
    end else if (!neg_q && div_res.quotient[DATA_W-1]) begin
      q_ovf    = 1'b1;
      q_result = RES_MAX;
    end else if (neg_q && div_res.quotient[DATA_W-1] &&
                 (|div_res.quotient[DATA_W-2:0])) begin
      q_ovf    = 1'b1;
      q_result = RES_MIN;
    end
  end

  assign cnt_next = (item_q.matrix_end || (cnt_q == AW'(MAX_ORDER - 1))) ?
                    '0 : cnt_q + AW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      cnt_q       <= '0;
      acc_q       <= '0;
      acc_sat_q   <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && !emit_fire) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            if (in_data_i.column_end) begin
              state_q <= ST_NUM;
            end else if (row_in_range) begin
              state_q <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          state_q <= ST_ACC;
        end
        ST_ACC: begin
          acc_q   <= sum_ovf ? (acc_q[ACC_W-1] ? ACC_MIN : ACC_MAX) : sum;
          if (sum_ovf) begin
            acc_sat_q <= 1'b1;
          end
          state_q <= ST_IDLE;
        end
        ST_NUM: begin
          state_q <= (item_q.entry_value == '0) ? ST_EMIT : ST_DSTART;
        end
        ST_DSTART: begin
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (div_res.done) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_fire) begin
            out_valid_q                <= 1'b1;
            out_data_q.solution_value  <= $signed(result_q);
            out_data_q.solution_index  <= IDX_W'(cnt_q);
            out_data_q.zero_pivot      <= zp_q;
            out_data_q.overflow        <= ovf_q;
            out_data_q.last_result     <= item_q.matrix_end;
            cnt_q                      <= cnt_next;
            acc_q                      <= '0;
            acc_sat_q                  <= 1'b0;
            state_q                    <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= in_data_i;
    end
    if (state_q == ST_MUL) begin
      product_q <= product_d;
    end
    if (state_q == ST_NUM) begin
      num_q    <= diff_ovf ? (scaled_b[ACC_W-1] ? ACC_MIN : ACC_MAX) : diff;
      neg_q    <= (diff_ovf ? scaled_b[ACC_W-1] : diff[ACC_W-1]) ^
                  item_q.entry_value[DATA_W-1];
      ovf_q    <= acc_sat_q | diff_ovf;
      zp_q     <= (item_q.entry_value == '0);
      result_q <= '0;
    end
    if ((state_q == ST_DIV) && div_res.done) begin
      result_q <= q_result;
      ovf_q    <= ovf_q | q_ovf;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `SFS_ASSERT_SAME(a_zp_value_zero, out_valid_o && out_data_o.zero_pivot, out_data_o.solution_value == '0, "zero pivot with nonzero value")
  `SFS_ASSERT_SAME(a_div_done_in_div, div_res.done, state_q == ST_DIV, "divider done outside divide")
  `SFS_ASSERT_NEXT(a_acc_clear, emit_fire, (acc_q == '0) && !acc_sat_q, "accumulator not cleared after transfer")
  `SFS_ASSERT_NEXT(a_cnt_restart, emit_fire && item_q.matrix_end, cnt_q == '0, "column counter not reset at matrix end")

endmodule
